@@ hdl/ssi_pkg.sv @@
// Shared types and constants for the syscall site identifier.
// Used by the window cell, the result queue and the top level.
package ssi_pkg;

  localparam int WINDOW_DEPTH_DEF = 10;
  localparam int COUNT_WIDTH_DEF  = 32;
  localparam int CFG_INDEX_W      = 2;

  localparam logic [31:0] SVC_WORD  = 32'hd400_0001;
  localparam logic [11:0] MOVZ_TAG  = 12'hd28;
  localparam logic [5:0]  BL_TAG    = 6'h25;
  localparam logic [4:0]  RD_SVC    = 5'd8;
  localparam logic [4:0]  RD_WRAP   = 5'd0;

  localparam logic [1:0] KIND_SVC     = 2'd0;
  localparam logic [1:0] KIND_WRAP    = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_WRAPPER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE    = 2'd1;

  typedef struct packed {
    logic [31:0] instr_word;
    logic        end_of_code;
  } in_t;

  typedef struct packed {
    logic [1:0]  report_kind;
    logic [63:0] site_address;
    logic [15:0] call_number;
    logic [31:0] sites_found;
    logic [31:0] sites_identified;
    logic        end_of_run;
  } out_t;

  // Search result handed from a nearer window cell to the next older one.
  typedef struct packed {
    logic        hit_svc;
    logic [15:0] imm_svc;
    logic        hit_wrap;
    logic [15:0] imm_wrap;
  } srch_t;

endpackage

@@ hdl/ssi_cell.sv @@
// One window cell: holds a recent code word and its valid mark.
// Depends on ssi_pkg for the search struct and the move-wide constants.
module ssi_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  logic          clear,
  input  logic [31:0]   word_in,
  input  logic          valid_in,
  input  ssi_pkg::srch_t srch_in,
  output logic [31:0]   word_out,
  output logic          valid_out,
  output ssi_pkg::srch_t srch_out
);
  import ssi_pkg::*;

  logic [31:0] word_r;
  logic        valid_r;
  logic        is_movz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= clear ? 1'b0 : valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= word_in;
    end
  end

  assign is_movz = valid_r && (word_r[31:20] == MOVZ_TAG);

  // A nearer cell that already matched wins; otherwise this cell may match.
  always_comb begin
    srch_out = srch_in;
    if (!srch_in.hit_svc && is_movz && (word_r[4:0] == RD_SVC)) begin
      srch_out.hit_svc = 1'b1;
      srch_out.imm_svc = word_r[20:5];
    end
    if (!srch_in.hit_wrap && is_movz && (word_r[4:0] == RD_WRAP)) begin
      srch_out.hit_wrap = 1'b1;
      srch_out.imm_wrap = word_r[20:5];
    end
  end

  assign word_out  = word_r;
  assign valid_out = valid_r;

endmodule

@@ hdl/ssi_outq.sv @@
// Four-entry result queue that takes up to two results per cycle.
// Depends on ssi_pkg for the result struct.
module ssi_outq (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [1:0]   push_n,
  input  ssi_pkg::out_t ent0,
  input  ssi_pkg::out_t ent1,
  input  logic         pop,
  output ssi_pkg::out_t head,
  output logic         nonempty,
  output logic [2:0]   count
);
  import ssi_pkg::*;

  out_t       mem [0:3];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] wr_p1;

  assign wr_p1 = wr_r + 2'd1;

  always_comb begin
    wr_nxt  = wr_r + push_n;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push_n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_r] <= ent0;
    end
    if (push_n == 2'd2) begin
      mem[wr_p1] <= ent1;
    end
  end

  assign head     = mem[rd_r];
  assign nonempty = (cnt_r != 3'd0);
  assign count    = cnt_r;

endmodule

@@ hdl/syscall_site_identifier.sv @@
// Syscall site identifier: scans a stream of 32-bit ARM code words for
// supervisor calls and wrapper calls and reports the call number found.
//
// Input channel in_valid/in_stall/in_data carries one code word per
// transaction; end_of_code marks the last word of the code. The result
// channel out_valid/out_stall/out_data carries report transactions, and
// the cfg_valid/cfg_ready port writes the wrapper address (index 0) and
// the code base address (index 1). cfg_ready is always high; writes must
// be made only while the block is idle, which the block does not enforce.
// One code word is taken per cycle while in_stall is low. A word that is
// a call site, or that ends the code, puts its results into a four-entry
// queue, and the first result is in the queue on the cycle after the word
// was accepted. A word that ends the code and is also a site writes both
// its results in the same cycle. The search runs through a chain of
// WINDOW_DEPTH cells, nearest word first, within the accepting cycle.
// in_stall rises when the queue holds three or more results. A word that
// is a site and ends the code can still be taken with two results waiting,
// so a receiver that stalls backs the stream up once three or four results
// wait. Reset clears the window, the address tracking, the counters, the
// queue and both registers.
module syscall_site_identifier #(
  parameter int WINDOW_DEPTH = ssi_pkg::WINDOW_DEPTH_DEF,
  parameter int COUNT_WIDTH  = ssi_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ssi_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ssi_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);
  import ssi_pkg::*;

  logic [63:0] wrapper_r;
  logic [63:0] base_r;
  logic [63:0] addr_r, addr_nxt;
  logic [61:0] off_r, off_nxt;
  logic [COUNT_WIDTH-1:0] found_r, found_nxt;
  logic [COUNT_WIDTH-1:0] ident_r, ident_nxt;

  logic        accept;
  logic        cfg_we;
  logic        last;
  logic [31:0] instr;
  logic [63:0] bl_target;
  logic        is_svc;
  logic        is_wrap;
  logic        site;
  logic        ok;
  logic [15:0] num;

  logic [31:0] word_o  [0:WINDOW_DEPTH-1];
  logic        valid_o [0:WINDOW_DEPTH-1];
  srch_t       srch_o  [0:WINDOW_DEPTH-1];
  srch_t       srch_fin;

  out_t        site_res;
  out_t        sum_res;
  out_t        ent0;
  logic [1:0]  push_n;
  logic        pop;
  logic        q_nonempty;
  logic [2:0]  q_count;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign instr     = in_data.instr_word;
  assign last      = in_data.end_of_code;

  // Window cells, cell 0 holding the most recent word.
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic [31:0] w_in;
    logic        v_in;
    srch_t       s_in;
    if (i == 0) begin : g_first
      assign w_in = instr;
      assign v_in = 1'b1;
      assign s_in = '0;
    end else begin : g_next
      assign w_in = word_o[i-1];
      assign v_in = valid_o[i-1];
      assign s_in = srch_o[i-1];
    end
    ssi_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .clear    (last),
      .word_in  (w_in),
      .valid_in (v_in),
      .srch_in  (s_in),
      .word_out (word_o[i]),
      .valid_out(valid_o[i]),
      .srch_out (srch_o[i])
    );
  end

  assign srch_fin = srch_o[WINDOW_DEPTH-1];

  assign bl_target = addr_r + {{36{instr[25]}}, instr[25:0], 2'b00};
  assign is_svc    = (instr == SVC_WORD);
  assign is_wrap   = !is_svc && (instr[31:26] == BL_TAG) && (bl_target == wrapper_r);
  assign site      = is_svc || is_wrap;
  assign ok        = is_svc ? srch_fin.hit_svc : srch_fin.hit_wrap;
  assign num       = is_svc ? srch_fin.imm_svc : srch_fin.imm_wrap;

  always_comb begin
    found_nxt = found_r;
    ident_nxt = ident_r;
    if (site && (found_r != '1)) begin
      found_nxt = found_r + COUNT_WIDTH'(1);
    end
    if (site && ok && (ident_r != '1)) begin
      ident_nxt = ident_r + COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    site_res.report_kind      = ok ? (is_svc ? KIND_SVC : KIND_WRAP) : KIND_UNKNOWN;
    site_res.site_address     = addr_r;
    site_res.call_number      = ok ? num : 16'd0;
    site_res.sites_found      = 32'(found_nxt);
    site_res.sites_identified = 32'(ident_nxt);
    site_res.end_of_run       = !last;
    sum_res.report_kind       = KIND_SUMMARY;
    sum_res.site_address      = '0;
    sum_res.call_number       = '0;
    sum_res.sites_found       = 32'(found_nxt);
    sum_res.sites_identified  = 32'(ident_nxt);
    sum_res.end_of_run        = 1'b1;
    ent0   = site ? site_res : sum_res;
    push_n = accept ? ({1'b0, site} + {1'b0, last}) : 2'd0;
  end

  // The running site address follows the offset; a base write re-aims it.
  always_comb begin
    addr_nxt = addr_r;
    off_nxt  = off_r;
    if (accept) begin
      if (last) begin
        addr_nxt = base_r;
        off_nxt  = '0;
      end else begin
        addr_nxt = addr_r + 64'd4;
        off_nxt  = off_r + 62'd1;
      end
    end else if (cfg_we && (cfg_index == CFG_BASE)) begin
      addr_nxt = cfg_data + {off_r, 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrapper_r <= '0;
      base_r    <= '0;
      addr_r    <= '0;
      off_r     <= '0;
      found_r   <= '0;
      ident_r   <= '0;
    end else begin
      addr_r <= addr_nxt;
      off_r  <= off_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WRAPPER: wrapper_r <= cfg_data;
          CFG_BASE:    base_r    <= cfg_data;
          default:     ;
        endcase
      end
      if (accept) begin
        found_r <= last ? '0 : found_nxt;
        ident_r <= last ? '0 : ident_nxt;
      end
    end
  end

  assign pop = q_nonempty && !out_stall;

  ssi_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_n  (push_n),
    .ent0    (ent0),
    .ent1    (sum_res),
    .pop     (pop),
    .head    (out_data),
    .nonempty(q_nonempty),
    .count   (q_count)
  );

  assign out_valid = q_nonempty;
  assign in_stall  = (q_count >= 3'd3);

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= 3'd4)
    else $error("result queue overfilled");

  a_ident_le_found: assert property (@(posedge clk) disable iff (!rst_n)
    ident_r <= found_r)
    else $error("identified count exceeds found count");

  a_end_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (addr_r == base_r) && (found_r == '0) && !valid_o[0])
    else $error("end of code did not clear the scan state");

  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty result queue");

endmodule

@@ tb/sv/tb_syscall_site_identifier.sv @@
// Self-checking testbench for syscall_site_identifier: drives code words, predicts
// every report, and compares the report stream field by field under random idling.
// Depends on ssi_pkg and the syscall_site_identifier RTL only.
module tb_syscall_site_identifier;
  timeunit 1ns;
  timeprecision 1ps;

  import ssi_pkg::*;

  localparam int WIN            = WINDOW_DEPTH_DEF;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 195;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_WRAPPER;
  logic [63:0]            cfg_data  = '0;

  syscall_site_identifier u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: register copies plus the scan window and counters.
  logic [63:0] reg_wrapper = '0;
  logic [63:0] reg_base    = '0;
  logic [31:0] win_words[WIN];
  int          win_fill    = 0;
  logic [63:0] word_count  = '0;
  logic [31:0] sites_seen  = '0;
  logic [31:0] sites_named = '0;

  out_t pending_reports[$];
  int   mismatches    = 0;
  int   items_sent    = 0;
  int   quiet_cycles  = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_req      = 1'b0;
  int   hold_left     = 0;

  initial begin
    for (int i = 0; i < WIN; i++) win_words[i] = '0;
  end

  function automatic logic [31:0] movz(input logic [4:0] rd, input logic [14:0] imm);
    // The tag covers bit 20, so a matching move carries a call number below 0x8000.
    return {MOVZ_TAG, imm, rd};
  endfunction

  function automatic logic [63:0] site_addr_now();
    return reg_base + (word_count << 2);
  endfunction

  // Branch-with-link that lands on target from the next word's address, if reachable.
  function automatic logic [31:0] bl_word(input logic [63:0] target);
    logic [63:0] delta;
    delta = target - site_addr_now();
    if (delta[1:0] == 2'b00 && (&delta[63:27] || ~|delta[63:27]))
      return {BL_TAG, delta[27:2]};
    return {BL_TAG, 26'($urandom)};
  endfunction

  function automatic logic [31:0] filler_word();
    case ($urandom_range(5))
      0: return movz(5'($urandom), 15'($urandom));
      1: return {MOVZ_TAG ^ (12'h1 << $urandom_range(11)), 15'($urandom),
                 ($urandom_range(1) == 0) ? RD_SVC : RD_WRAP};
      2: return {BL_TAG, 26'($urandom)};
      3: return SVC_WORD ^ (32'h1 << $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  function automatic void predict_reports(input logic [31:0] word, input logic last);
    logic [63:0] addr;
    logic [63:0] target;
    logic        is_svc;
    logic        is_wrap;
    logic        hit;
    logic [4:0]  rd;
    logic [15:0] num;
    out_t        rep;
    addr    = site_addr_now();
    target  = addr + {{36{word[25]}}, word[25:0], 2'b00};
    is_svc  = (word == SVC_WORD);
    is_wrap = !is_svc && word[31:26] == BL_TAG && target == reg_wrapper;
    if (is_svc || is_wrap) begin
      rd  = is_svc ? RD_SVC : RD_WRAP;
      hit = 1'b0;
      num = '0;
      for (int i = 0; i < win_fill; i++) begin
        if (!hit && win_words[i][31:20] == MOVZ_TAG && win_words[i][4:0] == rd) begin
          hit = 1'b1;
          num = win_words[i][20:5];
        end
      end
      if (sites_seen != '1) sites_seen++;
      if (hit && sites_named != '1) sites_named++;
      rep.report_kind      = hit ? (is_svc ? KIND_SVC : KIND_WRAP) : KIND_UNKNOWN;
      rep.site_address     = addr;
      rep.call_number      = num;
      rep.sites_found      = sites_seen;
      rep.sites_identified = sites_named;
      rep.end_of_run       = !last;
      pending_reports.push_back(rep);
    end
    for (int i = WIN - 1; i > 0; i--) win_words[i] = win_words[i-1];
    win_words[0] = word;
    if (win_fill < WIN) win_fill++;
    word_count++;
    if (last) begin
      rep.report_kind      = KIND_SUMMARY;
      rep.site_address     = '0;
      rep.call_number      = '0;
      rep.sites_found      = sites_seen;
      rep.sites_identified = sites_named;
      rep.end_of_run       = 1'b1;
      pending_reports.push_back(rep);
      for (int i = 0; i < WIN; i++) win_words[i] = '0;
      win_fill    = 0;
      word_count  = '0;
      sites_seen  = '0;
      sites_named = '0;
    end
  endfunction

  // Called at a rising edge; returns at the edge where the word was taken.
  // in_valid stays high afterwards so back-to-back words need no second assignment.
  task automatic send_word(input logic [31:0] word, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{instr_word: word, end_of_code: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_reports(word, last);
    items_sent++;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [63:0] wrapper, input logic [63:0] base);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WRAPPER;
    cfg_data  <= wrapper;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_wrapper = wrapper;
    cfg_index <= CFG_BASE;
    cfg_data  <= base;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_base = base;
    cfg_valid <= 1'b0;
  endtask

  // Mostly a move followed by a call site, with random distance and content.
  task automatic send_snippet();
    logic       to_svc;
    logic [4:0] rd;
    int         gap;
    if ($urandom_range(99) < 75) begin
      to_svc = 1'($urandom_range(1));
      rd     = to_svc ? RD_SVC : RD_WRAP;
      repeat ($urandom_range(2)) send_word(filler_word(), 1'b0);
      if ($urandom_range(9) != 0) send_word(movz(rd, 15'($urandom)), 1'b0);
      gap = ($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(4);
      repeat (gap) send_word(filler_word(), $urandom_range(59) == 0);
      send_word(to_svc ? SVC_WORD : bl_word(reg_wrapper), $urandom_range(14) == 0);
    end else begin
      send_word(filler_word(), $urandom_range(29) == 0);
    end
  endtask

  task automatic test_directed_sites();
    set_regs(64'h0000_0000_0040_0040, 64'h0000_0000_0040_0000);
    send_word(SVC_WORD, 1'b0);                 // nothing seen yet, so unidentified
    send_word(movz(RD_SVC, 15'h7fff), 1'b0);
    send_word(movz(RD_WRAP, 15'h0000), 1'b0);
    send_word(SVC_WORD, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(bl_word(reg_wrapper), 1'b0);
    send_word(32'hd29f_ffe8, 1'b0);            // bit 20 set: not a 64-bit move
    send_word(32'h5280_0108, 1'b0);            // 32-bit move into w8
    send_word(SVC_WORD, 1'b0);
    send_word(bl_word(reg_wrapper + 64'd4), 1'b0);
    send_word(bl_word(reg_wrapper - 64'd4), 1'b0);
    send_word(32'hd400_0002, 1'b0);
    repeat (WIN) send_word(32'h0000_0000, 1'b0);
    send_word(SVC_WORD, 1'b1);                 // moves out of the window; site then summary
    send_word(bl_word(reg_wrapper), 1'b1);     // fresh code after the clear
  endtask

  // Site addresses and branch targets crossing the top of the address space.
  task automatic test_address_wrap();
    wait_quiet();
    set_regs(64'hffff_ffff_ffff_fff8, 64'hffff_ffff_ffff_fff8);
    send_word(movz(RD_SVC, 15'h0010), 1'b0);
    send_word(movz(RD_WRAP, 15'h0020), 1'b0);
    send_word(SVC_WORD, 1'b0);
    send_word(bl_word(reg_wrapper), 1'b1);
  endtask

  task automatic test_random_phase(input int send_idle, input int stall,
                                   input logic [63:0] wrapper, input logic [63:0] base);
    int stop_at;
    wait_quiet();
    send_idle_pct = send_idle;
    stall_pct     = stall;
    set_regs(wrapper, base);
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) send_snippet();
  endtask

  // The receiver holds off while call sites keep arriving, filling the block.
  task automatic test_backpressure();
    wait_quiet();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req <= 1'b1;
    send_word(movz(RD_SVC, 15'($urandom)), 1'b0);
    repeat (30) send_word(SVC_WORD, 1'b0);
    send_word(filler_word(), 1'b1);
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_req  <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_reports
    out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected report transaction: kind %0d, site 0x%0h",
                 out_data.report_kind, out_data.site_address);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("report_kind", 64'(want.report_kind), 64'(out_data.report_kind));
          check_field("site_address", want.site_address, out_data.site_address);
          check_field("call_number", 64'(want.call_number), 64'(out_data.call_number));
          check_field("sites_found", 64'(want.sites_found), 64'(out_data.sites_found));
          check_field("sites_identified", 64'(want.sites_identified),
                      64'(out_data.sites_identified));
          check_field("end_of_run", 64'(want.end_of_run), 64'(out_data.end_of_run));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] rand_base;
    rand_base = {$urandom(), $urandom()};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_sites();
    test_address_wrap();
    test_random_phase(0, 0, 64'h0, 64'h0);
    test_random_phase(88, 0, '1, '1);
    test_random_phase(0, 88, 64'h40, 64'hffff_ffff_ffff_ff00);
    test_random_phase(31, 31, rand_base + {$urandom_range(600), 2'b00}, rand_base);
    test_backpressure();
    wait_quiet();
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
